// File: rtl/rtte_pkg.sv
// Shared types, constants and helpers of the adaptive RTT estimator.
package rtte_pkg;

    localparam int WINDOW_DEPTH_DEF = 10;
    localparam int TIME_WIDTH_DEF   = 40;

    localparam int GAIN_W  = 17;
    localparam int WSIZE_W = 4;
    localparam int THETA_W = 11;
    localparam int INIT_W  = 40;
    localparam int CFG_AW  = 6;
    localparam int CFG_DW  = 64;

    localparam logic [GAIN_W-1:0]  ONE_Q16     = 17'd65536;
    localparam logic [GAIN_W-1:0]  ALPHA_RESET = 17'd8192;
    localparam logic [GAIN_W-1:0]  BETA_RESET  = 17'd16384;
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd4;
    localparam logic [THETA_W-1:0] THETA_RESET = 11'd512;
    localparam logic [INIT_W-1:0]  INIT_RESET  = 40'd1000000000;

    typedef enum logic [2:0] {
        REG_ALPHA,
        REG_BETA,
        REG_ADAPT,
        REG_CLAMP,
        REG_WSIZE,
        REG_THETA,
        REG_INIT
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_KDIV,
        ST_KGAIN,
        ST_WRITE,
        ST_SUM,
        ST_MSTART,
        ST_MDIV,
        ST_THR,
        ST_PICK,
        ST_MULS,
        ST_MULV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  alpha;
        logic [GAIN_W-1:0]  beta;
        logic               adapt;
        logic               clamp;
        logic [WSIZE_W-1:0] wsize;
        logic [THETA_W-1:0] theta;
        logic [INIT_W-1:0]  init;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic kdiv_start;
        logic div_step;
        logic k_latch;
        logic win_write;
        logic sum_step;
        logic mdiv_start;
        logic thr_mul;
        logic pick;
        logic mul_s;
        logic mul_v;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic have;
        logic adapt;
        logic clamp;
        logic fill_lt2;
        logic sum_last;
        logic out_free;
    } sts_t;

    function automatic logic [2:0] gain_shift(input logic [GAIN_W-1:0] g);
        logic [2:0] s;
        s = 3'd0;
        for (int i = 5; i >= 1; i--) begin
            if (g == (ONE_Q16 >> i)) begin
                s = 3'(i);
            end
        end
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] gain_sat(input logic [GAIN_W-1:0] g);
        return (g > ONE_Q16) ? ONE_Q16 : g;
    endfunction

endpackage

// File: rtl/adaptive_rtt_estimator.sv
// Adaptive RTT estimator top level: register file and controller/datapath pair.
//
// Input stream: s_tdata carries one RTT sample in ns, s_tuser selects a measurement
// (0) or a reset of the estimator state (1). Every request yields exactly one result
// on the output stream: srtt, rttvar and rto = srtt + 4 * rttvar in m_tdata, and the
// spike-clamp flag in m_tuser.
// Steps: a reset request or the first sample is decided and then goes to the result register.
// A plain update runs the srtt and rttvar products and the update. Adaptive gains add
// a bit-serial change-rate divide; spike clamping adds a window sum, a bit-serial
// mean divide and the threshold product and compare. One request is worked at a time;
// a single restoring divider is shared by both divides. The next request is taken
// while a finished result waits in the output register; when the receiver stalls, the
// block finishes that request and holds before loading. Reset empties the window,
// loads srtt from initial_estimate and the register file from its defaults. The user
// must write registers over the APB port only while idle; the block does not enforce it.
module adaptive_rtt_estimator #(
    parameter int WINDOW_DEPTH = rtte_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_WIDTH   = rtte_pkg::TIME_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // rtt_sample
    input  logic [((TIME_WIDTH+7)/8)*8-1:0]        s_tdata,
    // mode
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // smoothed_rtt, rtt_variation, retransmit_timeout
    output logic [((3*TIME_WIDTH+3+7)/8)*8-1:0]    m_tdata,
    // spike_clamped
    output logic                                   m_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rtte_pkg::CFG_AW-1:0]            paddr,
    input  logic [rtte_pkg::CFG_DW-1:0]            pwdata,
    output logic [rtte_pkg::CFG_DW-1:0]            prdata,
    output logic                                   pready
);
    import rtte_pkg::*;

    localparam int OUT_DW = ((3*TIME_WIDTH+3+7)/8)*8;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    reg_idx_t   idx;
    logic       wr_en;
    logic [TIME_WIDTH-1:0] o_srtt, o_var;
    logic [TIME_WIDTH+2:0] o_rto;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha <= ALPHA_RESET;
            cfg_reg.beta  <= BETA_RESET;
            cfg_reg.adapt <= 1'b0;
            cfg_reg.clamp <= 1'b0;
            cfg_reg.wsize <= WSIZE_RESET;
            cfg_reg.theta <= THETA_RESET;
            cfg_reg.init  <= INIT_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_ALPHA: cfg_reg.alpha <= pwdata[GAIN_W-1:0];
                REG_BETA:  cfg_reg.beta  <= pwdata[GAIN_W-1:0];
                REG_ADAPT: cfg_reg.adapt <= pwdata[0];
                REG_CLAMP: cfg_reg.clamp <= pwdata[0];
                REG_WSIZE: cfg_reg.wsize <= pwdata[WSIZE_W-1:0];
                REG_THETA: cfg_reg.theta <= pwdata[THETA_W-1:0];
                REG_INIT:  cfg_reg.init  <= pwdata[INIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ALPHA: prdata = CFG_DW'(cfg_reg.alpha);
            REG_BETA:  prdata = CFG_DW'(cfg_reg.beta);
            REG_ADAPT: prdata = CFG_DW'(cfg_reg.adapt);
            REG_CLAMP: prdata = CFG_DW'(cfg_reg.clamp);
            REG_WSIZE: prdata = CFG_DW'(cfg_reg.wsize);
            REG_THETA: prdata = CFG_DW'(cfg_reg.theta);
            REG_INIT:  prdata = CFG_DW'(cfg_reg.init);
            default:   prdata = '0;
        endcase
    end

    rtte_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtte_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_tuser),
        .in_sample  (s_tdata[TIME_WIDTH-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_srtt   (o_srtt),
        .out_rttvar (o_var),
        .out_rto    (o_rto),
        .out_flag   (m_tuser)
    );

    assign m_tdata = OUT_DW'({o_rto, o_var, o_srtt});

endmodule

// File: rtl/rtte_ctrl.sv
// Sequencer of the RTT estimator: walks one request through its steps.
module rtte_ctrl #(
    parameter int TIME_WIDTH = rtte_pkg::TIME_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rtte_pkg::sts_t  sts,
    output rtte_pkg::cmd_t  cmd
);
    import rtte_pkg::*;

    localparam int NW = TIME_WIDTH + 16;
    localparam int CW = $clog2(NW + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            div_last;

    assign div_last = (cnt_reg == CW'(NW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                if (sts.mode || !sts.have) begin
                    state_next = ST_DONE;
                end else if (sts.adapt) begin
                    cmd.kdiv_start = 1'b1;
                    state_next     = ST_KDIV;
                end else if (sts.clamp) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_MULS;
                end
            end
            ST_KDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_last) begin
                    state_next = ST_KGAIN;
                end
            end
            ST_KGAIN: begin
                cmd.k_latch = 1'b1;
                state_next  = sts.clamp ? ST_WRITE : ST_MULS;
            end
            ST_WRITE: begin
                cmd.win_write = 1'b1;
                state_next    = sts.fill_lt2 ? ST_MULS : ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last) begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART: begin
                cmd.mdiv_start = 1'b1;
                cnt_next       = '0;
                state_next     = ST_MDIV;
            end
            ST_MDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_last) begin
                    state_next = ST_THR;
                end
            end
            ST_THR: begin
                cmd.thr_mul = 1'b1;
                state_next  = ST_PICK;
            end
            ST_PICK: begin
                cmd.pick   = 1'b1;
                state_next = ST_MULS;
            end
            ST_MULS: begin
                cmd.mul_s  = 1'b1;
                state_next = ST_MULV;
            end
            ST_MULV: begin
                cmd.mul_v  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECIDE))
        else $error("accepted request not decoded");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending one");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KDIV || state_reg == ST_MDIV) |-> (cnt_reg < CW'(NW)))
        else $error("divide counter overrun");

endmodule

// File: rtl/rtte_dp.sv
// Datapath of the RTT estimator: estimator state, window, divider, multiplier, result stage.
module rtte_dp #(
    parameter int WINDOW_DEPTH = rtte_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_WIDTH   = rtte_pkg::TIME_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rtte_pkg::cfg_t          cfg,
    input  rtte_pkg::cmd_t          cmd,
    output rtte_pkg::sts_t          sts,
    input  logic                    in_mode,
    input  logic [TIME_WIDTH-1:0]   in_sample,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TIME_WIDTH-1:0]   out_srtt,
    output logic [TIME_WIDTH-1:0]   out_rttvar,
    output logic [TIME_WIDTH+2:0]   out_rto,
    output logic                    out_flag
);
    import rtte_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int NW = TW + 16;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int HW = $clog2(WINDOW_DEPTH);
    localparam int SW = TW + FW;
    localparam int PW = TW + GAIN_W;
    localparam int XW = TW + 6;

    logic              mode_reg, have_reg;
    logic [TW-1:0]     samp_reg, srtt_reg, rttvar_reg, prev_reg;
    logic [GAIN_W-1:0] ga_reg, gb_reg;
    logic              shift_reg;
    logic [2:0]        s_reg, v_reg;
    logic              prevz_reg, dge_reg;
    logic [NW-1:0]     num_reg, quo_reg;
    logic [TW-1:0]     rem_reg, dvs_reg;
    logic [TW-1:0]     win_mem [WINDOW_DEPTH];
    logic [HW-1:0]     head_reg, rd_idx_reg;
    logic [FW-1:0]     fill_reg, sum_cnt_reg;
    logic [TW-1:0]     rdata_reg;
    logic [SW-1:0]     sum_reg;
    logic [TW-1:0]     mean_reg, p_reg, e_reg, qs_reg;
    logic [PW-1:0]     prod_reg;
    logic              flag_reg, up_reg, ge_reg;
    logic              ovalid_reg;
    logic [TW-1:0]     osrtt_reg, ovar_reg;
    logic [TW+2:0]     orto_reg;
    logic              oflag_reg;

    logic [4:0]        ws_ext;
    logic [FW-1:0]     win, fill_new;
    logic [HW-1:0]     head_inc, rd_dec;
    logic [TW:0]       div_t;
    logic              div_ge;
    logic [TW-1:0]     d_now, e_now, dv_now, qv;
    logic              up_now, ge_now;
    logic [GAIN_W-1:0] a_sat, b_sat, k_now;
    logic [GAIN_W:0]   ka_sum, kb_dif;
    logic [TW+THETA_W-1:0] thr_prod;
    logic [PW-1:0]     es_prod, ev_prod;
    logic [XW-1:0]     sh_srtt, sh_var;

    assign ws_ext   = {1'b0, cfg.wsize};
    assign win      = (ws_ext < 5'd2) ? FW'(2) :
                      (ws_ext > 5'(WINDOW_DEPTH)) ? FW'(WINDOW_DEPTH) : FW'(ws_ext);
    assign fill_new = (fill_reg < win) ? fill_reg + 1'b1 : win;
    assign head_inc = (head_reg == HW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign rd_dec   = (rd_idx_reg == '0) ? HW'(WINDOW_DEPTH - 1) : rd_idx_reg - 1'b1;

    assign div_t  = {rem_reg, num_reg[NW-1]};
    assign div_ge = (div_t >= {1'b0, dvs_reg});

    assign d_now = (samp_reg >= prev_reg) ? samp_reg - prev_reg : prev_reg - samp_reg;
    assign a_sat = gain_sat(cfg.alpha);
    assign b_sat = gain_sat(cfg.beta);
    assign k_now = prevz_reg ? '0 : dge_reg ? ONE_Q16 : {1'b0, quo_reg[15:0]};
    assign ka_sum = {1'b0, ONE_Q16} + {1'b0, k_now};
    assign kb_dif = {1'b0, ONE_Q16} - {1'b0, k_now};

    assign thr_prod = quo_reg[TW-1:0] * cfg.theta;

    assign up_now  = (p_reg >= srtt_reg);
    assign e_now   = up_now ? p_reg - srtt_reg : srtt_reg - p_reg;
    assign es_prod = e_now * ga_reg;
    assign ge_now  = (e_reg >= rttvar_reg);
    assign dv_now  = ge_now ? e_reg - rttvar_reg : rttvar_reg - e_reg;
    assign ev_prod = dv_now * gb_reg;
    assign qv      = TW'(prod_reg >> 16);

    assign sh_srtt = ((XW'(srtt_reg) << s_reg) - XW'(srtt_reg) + XW'(p_reg)) >> s_reg;
    assign sh_var  = ((XW'(rttvar_reg) << v_reg) - XW'(rttvar_reg) + XW'(e_reg)) >> v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg   <= 1'b0;
            srtt_reg   <= TW'(INIT_RESET);
            rttvar_reg <= '0;
            prev_reg   <= '0;
            fill_reg   <= '0;
            head_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.decide) begin
                if (mode_reg) begin
                    have_reg   <= 1'b0;
                    srtt_reg   <= TW'(cfg.init);
                    rttvar_reg <= '0;
                    prev_reg   <= '0;
                    fill_reg   <= '0;
                    head_reg   <= '0;
                end else if (!have_reg) begin
                    have_reg   <= 1'b1;
                    srtt_reg   <= samp_reg;
                    rttvar_reg <= samp_reg >> 1;
                    prev_reg   <= samp_reg;
                end
            end
            if (cmd.win_write) begin
                head_reg <= head_inc;
                fill_reg <= fill_new;
            end
            if (cmd.update) begin
                if (shift_reg) begin
                    srtt_reg   <= TW'(sh_srtt);
                    rttvar_reg <= TW'(sh_var);
                end else begin
                    srtt_reg   <= up_reg ? srtt_reg + qs_reg : srtt_reg - qs_reg;
                    rttvar_reg <= ge_reg ? rttvar_reg + qv : rttvar_reg - qv;
                end
                prev_reg <= samp_reg;
            end
            if (cmd.out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            samp_reg <= in_sample;
        end
        if (cmd.decide) begin
            ga_reg    <= a_sat;
            gb_reg    <= b_sat;
            s_reg     <= gain_shift(a_sat);
            v_reg     <= gain_shift(b_sat);
            shift_reg <= !cfg.adapt && !cfg.clamp &&
                         (gain_shift(a_sat) != 3'd0) && (gain_shift(b_sat) != 3'd0);
            prevz_reg <= (prev_reg == '0);
            dge_reg   <= (d_now >= prev_reg);
            p_reg     <= samp_reg;
            flag_reg  <= 1'b0;
        end
        if (cmd.kdiv_start) begin
            num_reg <= {d_now, 16'b0};
            dvs_reg <= prev_reg;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.mdiv_start) begin
            num_reg <= NW'(sum_reg);
            dvs_reg <= TW'(fill_reg);
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? TW'(div_t - {1'b0, dvs_reg}) : div_t[TW-1:0];
            quo_reg <= {quo_reg[NW-2:0], div_ge};
            num_reg <= num_reg << 1;
        end
        if (cmd.k_latch) begin
            ga_reg <= GAIN_W'(ka_sum >> 3);
            gb_reg <= GAIN_W'(kb_dif >> 2);
        end
        if (cmd.win_write) begin
            win_mem[head_reg] <= samp_reg;
            rd_idx_reg        <= head_reg;
            sum_reg           <= '0;
            sum_cnt_reg       <= '0;
        end
        if (cmd.sum_step) begin
            rdata_reg   <= win_mem[rd_idx_reg];
            rd_idx_reg  <= rd_dec;
            sum_cnt_reg <= sum_cnt_reg + 1'b1;
            if (sum_cnt_reg != '0) begin
                sum_reg <= sum_reg + SW'(rdata_reg);
            end
        end
        if (cmd.thr_mul) begin
            mean_reg <= quo_reg[TW-1:0];
            prod_reg <= PW'(thr_prod);
        end
        if (cmd.pick) begin
            if (PW'(samp_reg) > (prod_reg >> 8)) begin
                p_reg    <= mean_reg;
                flag_reg <= 1'b1;
            end
        end
        if (cmd.mul_s) begin
            e_reg    <= e_now;
            up_reg   <= up_now;
            prod_reg <= es_prod;
        end
        if (cmd.mul_v) begin
            qs_reg   <= TW'(prod_reg >> 16);
            ge_reg   <= ge_now;
            prod_reg <= ev_prod;
        end
        if (cmd.out_load) begin
            osrtt_reg <= srtt_reg;
            ovar_reg  <= rttvar_reg;
            orto_reg  <= (TW+3)'(srtt_reg) + ((TW+3)'(rttvar_reg) << 2);
            oflag_reg <= flag_reg;
        end
    end

    always_comb begin
        sts.mode     = mode_reg;
        sts.have     = have_reg;
        sts.adapt    = cfg.adapt;
        sts.clamp    = cfg.clamp;
        sts.fill_lt2 = (fill_new < FW'(2));
        sts.sum_last = (sum_cnt_reg == fill_reg);
        sts.out_free = !ovalid_reg || m_tready;
    end

    assign m_tvalid   = ovalid_reg;
    assign out_srtt   = osrtt_reg;
    assign out_rttvar = ovar_reg;
    assign out_rto    = orto_reg;
    assign out_flag   = oflag_reg;

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < HW'(WINDOW_DEPTH) || WINDOW_DEPTH == (1 << HW))
        else $error("window head beyond depth");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> ovalid_reg)
        else $error("loaded result not presented");

endmodule
